/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds
`define NNIS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// cond must never hold
`define NNIS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

`endif

/* rtl/core/nnis_pkg.sv */
// ----------------------------------------------------------------------------
// nnis_pkg
// types and constants shared by the nearest neighbor scaler modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nnis_pkg;

	localparam int IDX_W      = 30;
	localparam int VAL_W      = 16;
	localparam int SPAN_W     = 4;
	localparam int WIDE_W     = 16;
	localparam int CNT_W      = 3;
	localparam int KEPT_W     = 24;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;
	localparam int DIM_CFG_W  = 13;
	localparam int OUT_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_MODE_UP = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 4'd3;

	typedef struct packed {
		logic                 mode_up;
		logic [SPAN_W-1:0]    scale_factor;
		logic [DIM_CFG_W-1:0] frame_cols;
		logic [DIM_CFG_W-1:0] frame_rows;
	} cfg_t;

	// one pixel's worth of writes: an span x span block starting at idx
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [VAL_W-1:0]  value;
		logic [SPAN_W-1:0] span;
		logic [WIDE_W-1:0] wide;
	} entry_t;

endpackage

/* rtl/core/nnis_front.sv */
// ----------------------------------------------------------------------------
// nnis_front
// accepts pixels, tracks frame position, drops or forms a block descriptor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nnis_front #(
	parameter int MAX_DIM   = 4096,
	parameter int MAX_SCALE = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nnis_pkg::cfg_t             cfg,
	input  logic                       restart,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [nnis_pkg::VAL_W-1:0] s_axis_tdata,   // pixel_value
	output logic                       push,
	output nnis_pkg::entry_t           entry,
	input  logic                       q_full
);

	localparam int PW  = $clog2(MAX_DIM);
	localparam int DW  = PW + 1;
	localparam int SW  = nnis_pkg::SPAN_W;
	localparam int RSW = PW + SW;
	localparam int PRW = RSW + nnis_pkg::WIDE_W;
	localparam int PHW = nnis_pkg::CNT_W;

	logic [SW-1:0]  s_eff;
	logic [DW-1:0]  cols_eff;
	logic [DW-1:0]  rows_eff;

	logic [PW-1:0]  col_q;
	logic [PW-1:0]  row_q;
	logic [PHW-1:0] cph_q;
	logic [PHW-1:0] rph_q;
	logic [nnis_pkg::KEPT_W-1:0] kept_q;

	logic           v_s1;
	logic           up_s1;
	logic [nnis_pkg::VAL_W-1:0]  val_s1;
	logic [RSW-1:0] rs_s1;
	logic [RSW-1:0] cs_s1;
	logic [nnis_pkg::WIDE_W-1:0] wide_s1;
	logic [nnis_pkg::KEPT_W-1:0] kept_s1;
	logic [SW-1:0]  span_s1;

	logic           in_fire;
	logic           col_last;
	logic           row_last;
	logic           cph_last;
	logic           rph_last;
	logic           keep;
	logic [RSW-1:0] rs_d;
	logic [RSW-1:0] cs_d;
	logic [DW+SW-1:0] wide_d;
	logic [PRW-1:0] prod;

	always_comb begin
		if (cfg.scale_factor == '0) begin
			s_eff = SW'(1);
		end else if (32'(cfg.scale_factor) > 32'(MAX_SCALE)) begin
			s_eff = SW'(MAX_SCALE);
		end else begin
			s_eff = cfg.scale_factor;
		end
		if (cfg.frame_cols == '0) begin
			cols_eff = DW'(1);
		end else if (32'(cfg.frame_cols) > 32'(MAX_DIM)) begin
			cols_eff = DW'(MAX_DIM);
		end else begin
			cols_eff = DW'(cfg.frame_cols);
		end
		if (cfg.frame_rows == '0) begin
			rows_eff = DW'(1);
		end else if (32'(cfg.frame_rows) > 32'(MAX_DIM)) begin
			rows_eff = DW'(MAX_DIM);
		end else begin
			rows_eff = DW'(cfg.frame_rows);
		end
	end

	assign s_axis_tready = !v_s1 || !q_full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign push          = v_s1 && !q_full;

	assign col_last = (DW'(col_q) + DW'(1)) >= cols_eff;
	assign row_last = (DW'(row_q) + DW'(1)) >= rows_eff;
	assign cph_last = (SW'(cph_q) + SW'(1)) == s_eff;
	assign rph_last = (SW'(rph_q) + SW'(1)) == s_eff;
	assign keep     = cfg.mode_up || ((cph_q == '0) && (rph_q == '0));

	assign rs_d   = RSW'(row_q) * RSW'(s_eff);
	assign cs_d   = RSW'(col_q) * RSW'(s_eff);
	assign wide_d = (DW+SW)'(cols_eff) * (DW+SW)'(s_eff);

	// position and kept count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			kept_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (restart) begin
				col_q  <= '0;
				row_q  <= '0;
				cph_q  <= '0;
				rph_q  <= '0;
				kept_q <= '0;
			end else if (in_fire) begin
				if (col_last) begin
					col_q <= '0;
					cph_q <= '0;
					if (row_last) begin
						row_q <= '0;
						rph_q <= '0;
					end else begin
						row_q <= row_q + PW'(1);
						rph_q <= rph_last ? '0 : rph_q + PHW'(1);
					end
				end else begin
					col_q <= col_q + PW'(1);
					cph_q <= cph_last ? '0 : cph_q + PHW'(1);
				end
				if (col_last && row_last) begin
					kept_q <= '0;
				end else if (!cfg.mode_up && keep) begin
					kept_q <= kept_q + nnis_pkg::KEPT_W'(1);
				end
			end
			if (in_fire) begin
				v_s1 <= keep;
			end else if (!q_full) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			up_s1   <= cfg.mode_up;
			val_s1  <= s_axis_tdata;
			rs_s1   <= rs_d;
			cs_s1   <= cs_d;
			wide_s1 <= nnis_pkg::WIDE_W'(wide_d);
			kept_s1 <= kept_q;
			span_s1 <= cfg.mode_up ? s_eff : SW'(1);
		end
	end

	assign prod = PRW'(rs_s1) * PRW'(wide_s1);

	always_comb begin
		entry.value = val_s1;
		entry.span  = span_s1;
		entry.wide  = wide_s1;
		if (up_s1) begin
			entry.idx = nnis_pkg::IDX_W'(prod) + nnis_pkg::IDX_W'(cs_s1);
		end else begin
			entry.idx = nnis_pkg::IDX_W'(kept_s1);
		end
	end

endmodule

/* rtl/core/nnis_fifo.sv */
// ----------------------------------------------------------------------------
// nnis_fifo
// small register queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nnis_fifo #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/core/nnis_back.sv */
// ----------------------------------------------------------------------------
// nnis_back
// expands each block descriptor into writes, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nnis_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nnis_pkg::entry_t                entry,
	input  logic                            q_valid,
	output logic                            q_pop,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [nnis_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // dest_index, dest_value, pad
	output logic                            m_axis_tlast    // run_last
);

	localparam int SW  = nnis_pkg::SPAN_W;
	localparam int CW  = nnis_pkg::CNT_W;
	localparam int IW  = nnis_pkg::IDX_W;
	localparam int VW  = nnis_pkg::VAL_W;
	localparam int PADW = nnis_pkg::OUT_DATA_W - IW - VW;

	logic                        busy_q;
	logic [IW-1:0]               cur_idx_q;
	logic [IW-1:0]               row_idx_q;
	logic [VW-1:0]               val_q;
	logic [SW-1:0]               span_q;
	logic [nnis_pkg::WIDE_W-1:0] wide_q;
	logic [CW-1:0]               l_q;
	logic [CW-1:0]               k_q;

	logic                        out_v_q;
	logic [IW-1:0]               out_idx_q;
	logic [VW-1:0]               out_val_q;
	logic                        out_last_q;

	logic          advance;
	logic          emit;
	logic          last_l;
	logic          last_k;
	logic          last;
	logic [IW-1:0] next_row;

	assign advance  = !out_v_q || m_axis_tready;
	assign emit     = advance && busy_q;
	assign last_l   = (SW'(l_q) + SW'(1)) == span_q;
	assign last_k   = (SW'(k_q) + SW'(1)) == span_q;
	assign last     = last_l && last_k;
	assign q_pop    = q_valid && (!busy_q || (emit && last));
	assign next_row = row_idx_q + IW'(wide_q);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {PADW'(0), out_val_q, out_idx_q};
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (advance) begin
				out_v_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_idx_q  <= cur_idx_q;
			out_val_q  <= val_q;
			out_last_q <= last;
		end
		if (q_pop) begin
			cur_idx_q <= entry.idx;
			row_idx_q <= entry.idx;
			val_q     <= entry.value;
			span_q    <= entry.span;
			wide_q    <= entry.wide;
			l_q       <= '0;
			k_q       <= '0;
		end else if (emit && !last) begin
			if (last_l) begin
				cur_idx_q <= next_row;
				row_idx_q <= next_row;
				l_q       <= '0;
				k_q       <= k_q + CW'(1);
			end else begin
				cur_idx_q <= cur_idx_q + IW'(1);
				l_q       <= l_q + CW'(1);
			end
		end
	end

endmodule

/* rtl/core/nearest_neighbor_integer_scaler.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_integer_scaler
// nearest neighbor up/down scaler producing indexed writes of the new frame
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: pixel_value
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: dest_index, dest_value; tlast: run_last
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// up mode: scale*scale writes per pixel, one per cycle from the output port while it is not stalled
// down mode: each pixel is kept or dropped; a kept pixel gives a single write
// front stage register, four entry queue, back registers; the queue lets either side stall
// no clearing pass after reset; cfg_ready is always high
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_neighbor_integer_scaler #(
	parameter int MAX_DIM   = 4096,
	parameter int MAX_SCALE = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [nnis_pkg::VAL_W-1:0]           s_axis_tdata,   // pixel_value
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [nnis_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // dest_index, dest_value, pad
	output logic                                 m_axis_tlast,   // run_last
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [nnis_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nnis_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int QW = $bits(nnis_pkg::entry_t);

	nnis_pkg::cfg_t   cfg_q;
	nnis_pkg::entry_t push_entry;
	nnis_pkg::entry_t pop_entry;
	logic             cfg_fire;
	logic             restart;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign restart   = cfg_fire && (cfg_index <= nnis_pkg::REG_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_up      <= 1'b1;
			cfg_q.scale_factor <= nnis_pkg::SPAN_W'(2);
			cfg_q.frame_cols   <= nnis_pkg::DIM_CFG_W'(640);
			cfg_q.frame_rows   <= nnis_pkg::DIM_CFG_W'(480);
		end else if (cfg_fire) begin
			unique case (cfg_index)
				nnis_pkg::REG_MODE_UP: begin
					cfg_q.mode_up <= cfg_data[0];
				end
				nnis_pkg::REG_SCALE: begin
					cfg_q.scale_factor <= cfg_data[nnis_pkg::SPAN_W-1:0];
				end
				nnis_pkg::REG_COLS: begin
					cfg_q.frame_cols <= cfg_data[nnis_pkg::DIM_CFG_W-1:0];
				end
				nnis_pkg::REG_ROWS: begin
					cfg_q.frame_rows <= cfg_data[nnis_pkg::DIM_CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	nnis_front #(
		.MAX_DIM   (MAX_DIM),
		.MAX_SCALE (MAX_SCALE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.restart       (restart),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push          (q_push),
		.entry         (push_entry),
		.q_full        (q_full)
	);

	nnis_fifo #(
		.WIDTH (QW),
		.DEPTH (4)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (push_entry),
		.pop     (q_pop),
		.rd_data (pop_entry),
		.full    (q_full),
		.empty   (q_empty)
	);

	nnis_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry         (pop_entry),
		.q_valid       (!q_empty),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	`NNIS_ASSERT_IMPLIES(a_pop_nonempty, clk, arst_n, q_pop, !q_empty)
	`NNIS_ASSERT_IMPLIES(a_accept_room, clk, arst_n, q_empty, s_axis_tready)
	`NNIS_ASSERT_NEVER(a_no_overflow, clk, arst_n, q_push && q_full)

endmodule

/* tb/sv/tb_nearest_neighbor_integer_scaler.sv */
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_integer_scaler
// self-checking bench for the nearest neighbor up/down scaler
// ----------------------------------------------------------------------------
// pixels are fed in raster order through the input stream; every accepted
// pixel is run through a behavioral scaler that tracks row, column and the
// decimation count and queues the writes it should cause. each write on the
// output stream is checked against the oldest queued write. the run starts
// with short directed frames covering register extremes, clamping, dropped
// pixels, frame wrap and register restarts, then random frames under
// several idle and stall patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_neighbor_integer_scaler;

	import nnis_pkg::*;

	localparam int SCALE_CAP = 8;
	localparam int DIM_CAP   = 4096;
	localparam int SEGMENTS  = 12;
	localparam int SEG_ITEMS = 12;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic             last;
	} write_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [VAL_W-1:0]      s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// scaler state as seen from outside
	logic                 mode_r;
	logic [SPAN_W-1:0]    scale_r;
	logic [DIM_CFG_W-1:0] cols_r;
	logic [DIM_CFG_W-1:0] rows_r;
	int unsigned          col_pos;
	int unsigned          row_pos;
	logic [KEPT_W-1:0]    kept_cnt;

	logic [VAL_W-1:0] pix_q[$];
	write_t           expected_writes[$];
	write_t           exp_w;

	int  send_pct = 0;
	int  recv_pct = 0;
	bit  hold_go = 1'b0;
	logic hold_rx = 1'b0;

	int err_count = 0;
	int n_items = 0;
	int n_up = 0;
	int n_down = 0;
	int n_writes = 0;
	int n_cfg = 0;

	nearest_neighbor_integer_scaler #(
		.MAX_DIM(DIM_CAP),
		.MAX_SCALE(SCALE_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void restart_frame();
		col_pos  = 0;
		row_pos  = 0;
		kept_cnt = '0;
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MODE_UP: mode_r = data[0];
			REG_SCALE: scale_r = data[SPAN_W-1:0];
			REG_COLS: cols_r = data;
			REG_ROWS: rows_r = data;
			default: return;
		endcase
		restart_frame();
	endfunction

	// queue the writes one pixel causes, then step the raster position
	function automatic void scale_pixel(logic [VAL_W-1:0] pix);
		int unsigned       s;
		int unsigned       cols;
		int unsigned       rows;
		longint unsigned   wide;
		longint unsigned   base;
		write_t            w;
		s    = clamp_cfg(32'(scale_r), SCALE_CAP);
		cols = clamp_cfg(32'(cols_r), DIM_CAP);
		rows = clamp_cfg(32'(rows_r), DIM_CAP);
		w.val = pix;
		if (mode_r) begin
			wide = longint'(cols) * s;
			for (int unsigned k = 0; k < s; k++) begin
				base = (longint'(row_pos) * s + k) * wide + longint'(col_pos) * s;
				for (int unsigned l = 0; l < s; l++) begin
					w.idx  = IDX_W'(base + l);
					w.last = (k + 1 == s) && (l + 1 == s);
					expected_writes.push_back(w);
				end
			end
			n_up++;
		end else begin
			if ((row_pos % s) == 0 && (col_pos % s) == 0) begin
				w.idx  = IDX_W'(kept_cnt);
				w.last = 1'b1;
				expected_writes.push_back(w);
				kept_cnt = kept_cnt + 1'b1;
			end
			n_down++;
		end
		if (col_pos + 1 >= cols) begin
			col_pos = 0;
			if (row_pos + 1 >= rows) begin
				row_pos  = 0;
				kept_cnt = '0;
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
		n_items++;
	endfunction

	function automatic void note_error(string msg);
		err_count++;
		if (err_count <= 10)
			$display("%s", msg);
	endfunction

	initial begin
		mode_r  = 1'b1;
		scale_r = 4'd2;
		cols_r  = 13'd640;
		rows_r  = 13'd480;
		restart_frame();
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				scale_pixel(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pix_q.size() != 0 && $urandom_range(99) >= send_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pix_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_writes.size() == 0) begin
					note_error($sformatf("unexpected write: idx=%0d val=%h last=%b",
						m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W+VAL_W-1:IDX_W],
						m_axis_tlast));
				end else begin
					exp_w = expected_writes.pop_front();
					if (m_axis_tdata[IDX_W-1:0] !== exp_w.idx
							|| m_axis_tdata[IDX_W+VAL_W-1:IDX_W] !== exp_w.val
							|| m_axis_tlast !== exp_w.last)
						note_error($sformatf(
							"write mismatch: exp idx=%0d val=%h last=%b, got idx=%0d val=%h last=%b",
							exp_w.idx, exp_w.val, exp_w.last, m_axis_tdata[IDX_W-1:0],
							m_axis_tdata[IDX_W+VAL_W-1:IDX_W], m_axis_tlast));
				end
				n_writes++;
			end
			m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_pct);
		end
	end

	// long output hold-off while the input keeps offering pixels
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (300) @(posedge clk);
		hold_rx <= 1'b0;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, data);
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(int sel);
		@(negedge clk);
		case (sel)
			0: begin send_pct = 0;  recv_pct = 0;  end
			1: begin send_pct = 59; recv_pct = 0;  end
			2: begin send_pct = 0;  recv_pct = 59; end
			default: begin send_pct = 15; recv_pct = 15; end
		endcase
	endtask

	task automatic feed(logic [VAL_W-1:0] v);
		@(negedge clk);
		pix_q.push_back(v);
	endtask

	task automatic feed_random(int n);
		@(negedge clk);
		repeat (n) pix_q.push_back(VAL_W'($urandom_range(65535)));
	endtask

	// wait for every pixel taken and every write seen, then let the pipe empty
	task automatic drain_block();
		while (pix_q.size() != 0 || s_axis_tvalid || expected_writes.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_setup();
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom_range(8191));
		d[0] = 1'($urandom_range(1));
		write_reg(REG_MODE_UP, d);
		d = CFG_DATA_W'($urandom_range(8191));
		d[SPAN_W-1:0] = ($urandom_range(9) < 7) ? SPAN_W'($urandom_range(1, 4))
			: SPAN_W'($urandom_range(15));
		write_reg(REG_SCALE, d);
		write_reg(REG_COLS, ($urandom_range(9) < 8) ? CFG_DATA_W'($urandom_range(1, 6))
			: CFG_DATA_W'($urandom_range(8191)));
		write_reg(REG_ROWS, ($urandom_range(9) < 8) ? CFG_DATA_W'($urandom_range(1, 5))
			: CFG_DATA_W'($urandom_range(8191)));
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom_range(8191)));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(0);

		// reset settings: upscale by two
		feed(16'h0000);
		feed(16'hffff);
		feed(16'h5a5a);
		drain_block();

		// decimate a 3x3 frame by two, then start the next frame
		write_reg(REG_MODE_UP, 13'd0);
		write_reg(REG_SCALE, 13'd2);
		write_reg(REG_COLS, 13'd3);
		write_reg(REG_ROWS, 13'd3);
		for (int i = 0; i < 11; i++)
			feed(VAL_W'(16'h1000 + i));
		drain_block();

		// zero scale and zero sizes act as one
		write_reg(REG_MODE_UP, 13'd1);
		write_reg(REG_SCALE, 13'd0);
		write_reg(REG_COLS, 13'd0);
		write_reg(REG_ROWS, 13'd0);
		feed(16'h8001);
		feed(16'h7ffe);
		drain_block();

		// oversized scale and sizes clamp to the maximum
		write_reg(REG_SCALE, 13'd15);
		write_reg(REG_COLS, 13'h1fff);
		write_reg(REG_ROWS, 13'h1fff);
		feed(16'hffff);
		feed(16'h0000);
		drain_block();

		// unknown index keeps the frame, a real write restarts it
		write_reg(REG_MODE_UP, 13'h1ffe);
		write_reg(REG_SCALE, 13'h1);
		write_reg(REG_COLS, 13'd4);
		feed(16'h0001);
		feed(16'h0002);
		drain_block();
		write_reg(CFG_IDX_W'(9), 13'h1fff);
		feed(16'h0003);
		feed(16'h0004);
		drain_block();
		write_reg(REG_ROWS, 13'h1fff);
		feed(16'h0005);
		feed(16'h0006);
		drain_block();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 4) begin
				// fill the block behind a stalled output
				set_idling(0);
				write_reg(REG_MODE_UP, 13'd1);
				write_reg(REG_SCALE, 13'd3);
				write_reg(REG_COLS, 13'd5);
				write_reg(REG_ROWS, 13'd4);
				@(negedge clk);
				hold_go = 1'b1;
				feed_random(SEG_ITEMS);
			end else if (seg == 5) begin
				set_idling(3);
				random_setup();
				feed_random(SEG_ITEMS / 2);
				drain_block();
				feed_random(SEG_ITEMS - SEG_ITEMS / 2);
			end else begin
				set_idling(seg % 4);
				random_setup();
				feed_random(SEG_ITEMS);
			end
			drain_block();
		end

		$display("covered %0d pixels (%0d upscaled, %0d decimated), %0d writes checked",
			n_items, n_up, n_down, n_writes);
		$display("%0d register writes incl. clamped scale/size and unknown index, %0d errors",
			n_cfg, err_count);
		if (err_count == 0)
			$display("tb_nearest_neighbor_integer_scaler: done, clean");
		else
			$display("tb_nearest_neighbor_integer_scaler: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("tb_nearest_neighbor_integer_scaler: done, errors");
		$finish;
	end

endmodule
